@@ design/tiny_register_cpu_execute_macros.svh @@
// Assertion macros shared by the execute block
`ifndef TINY_REGISTER_CPU_EXECUTE_MACROS_SVH
`define TINY_REGISTER_CPU_EXECUTE_MACROS_SVH

// Property checked on clk_i, off while rst_ni is low
`define TRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a check in the next
`define TRE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/tre_pkg.sv @@
// Types, constants and helper functions of the execute block
`default_nettype none
package tre_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned XLEN      = 32;
  localparam int unsigned IQ_DEPTH  = 2;
  localparam int unsigned RQ_DEPTH  = 2;

  localparam logic [XLEN-1:0] MIX_CONST  = 32'hA5A5_A5A5;
  localparam logic [XLEN-1:0] LOW_MASK   = 32'h0000_FFFF;
  localparam int unsigned     HALF_SHIFT = 16;

  localparam logic [4:0] OPC_MOV  = 5'd0;
  localparam logic [4:0] OPC_LOAD = 5'd1;
  localparam logic [4:0] OPC_XOR  = 5'd2;
  localparam logic [4:0] OPC_ROTL = 5'd3;
  localparam logic [4:0] OPC_ROTR = 5'd4;
  localparam logic [4:0] OPC_ADD  = 5'd5;
  localparam logic [4:0] OPC_SUB  = 5'd6;
  localparam logic [4:0] OPC_LOW  = 5'd7;
  localparam logic [4:0] OPC_HIGH = 5'd8;
  localparam logic [4:0] OPC_MIX  = 5'd9;
  localparam logic [4:0] OPC_HALT = 5'd10;

  typedef enum logic [3:0] {
    OP_MOV  = 4'd0,
    OP_LOAD = 4'd1,
    OP_XOR  = 4'd2,
    OP_ROTL = 4'd3,
    OP_ROTR = 4'd4,
    OP_ADD  = 4'd5,
    OP_SUB  = 4'd6,
    OP_LOW  = 4'd7,
    OP_HIGH = 4'd8,
    OP_MIX  = 4'd9,
    OP_HALT = 4'd10,
    OP_NOP  = 4'd11
  } op_e;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef struct packed {
    op_e        op;
    logic       wr_dest;
    logic       fold;
    reg_idx_t   dest;
    reg_idx_t   src_a;
    reg_idx_t   src_b;
    logic [1:0] imm;
  } instr_t;

  typedef struct packed {
    logic            executed;
    logic [XLEN-1:0] step_count;
    logic [XLEN-1:0] dest_value;
    logic [XLEN-1:0] acc_value;
    logic            halted;
  } res_t;

  function automatic logic [XLEN-1:0] rotl32(logic [XLEN-1:0] x, logic [1:0] n);
    logic [2*XLEN-1:0] t;
    t = {x, x} << n;
    return t[2*XLEN-1:XLEN];
  endfunction

  function automatic logic [XLEN-1:0] rotr32(logic [XLEN-1:0] x, logic [1:0] n);
    logic [2*XLEN-1:0] t;
    t = {x, x} >> n;
    return t[XLEN-1:0];
  endfunction

  function automatic logic [XLEN-1:0] mix32(logic [XLEN-1:0] x);
    return rotl32(x, 2'd1) ^ rotl32(x, 2'd3) ^ rotr32(x, 2'd2) ^ MIX_CONST;
  endfunction

endpackage
`default_nettype wire

@@ design/tre_fifo.sv @@
// Small synchronous queue with count, head visible while not empty
`default_nettype none
`include "tiny_register_cpu_execute_macros.svh"
module tre_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  `TRE_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

@@ design/tre_front.sv @@
// Front end: classifies a raw instruction into an execute request
`default_nettype none
module tre_front (
  input  wire logic [4:0]     opcode_i,
  input  wire logic [2:0]     dest_reg_i,
  input  wire logic [2:0]     src_a_i,
  input  wire logic [2:0]     src_b_i,
  input  wire logic [1:0]     small_imm_i,
  output tre_pkg::instr_t     instr_o
);

  tre_pkg::op_e op;

  always_comb begin
    case (opcode_i)
      tre_pkg::OPC_MOV:  op = tre_pkg::OP_MOV;
      tre_pkg::OPC_LOAD: op = tre_pkg::OP_LOAD;
      tre_pkg::OPC_XOR:  op = tre_pkg::OP_XOR;
      tre_pkg::OPC_ROTL: op = tre_pkg::OP_ROTL;
      tre_pkg::OPC_ROTR: op = tre_pkg::OP_ROTR;
      tre_pkg::OPC_ADD:  op = tre_pkg::OP_ADD;
      tre_pkg::OPC_SUB:  op = tre_pkg::OP_SUB;
      tre_pkg::OPC_LOW:  op = tre_pkg::OP_LOW;
      tre_pkg::OPC_HIGH: op = tre_pkg::OP_HIGH;
      tre_pkg::OPC_MIX:  op = tre_pkg::OP_MIX;
      tre_pkg::OPC_HALT: op = tre_pkg::OP_HALT;
      default:           op = tre_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    instr_o.op      = op;
    instr_o.wr_dest = (op != tre_pkg::OP_HALT) && (op != tre_pkg::OP_NOP);
    instr_o.fold    = (op == tre_pkg::OP_XOR) || (op == tre_pkg::OP_MIX);
    instr_o.dest    = tre_pkg::reg_idx_t'(dest_reg_i);
    instr_o.src_a   = tre_pkg::reg_idx_t'(src_a_i);
    instr_o.src_b   = tre_pkg::reg_idx_t'(src_b_i);
    instr_o.imm     = small_imm_i;
  end

endmodule
`default_nettype wire

@@ design/tre_back.sv @@
// Back end: register file, execute stage, step counter and halt flag
`default_nettype none
`include "tiny_register_cpu_execute_macros.svh"
module tre_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [tre_pkg::XLEN-1:0] cfg_wdata_i,
  input  wire tre_pkg::instr_t          instr_i,
  input  wire logic                     instr_valid_i,
  output logic                          instr_pop_o,
  output tre_pkg::res_t                 res_o,
  output logic                          res_push_o,
  input  wire logic                     res_full_i
);

  localparam int unsigned XLEN = tre_pkg::XLEN;
  localparam int unsigned NR   = tre_pkg::NUM_REGS;

  // two banks written together: one serves src_a/src_b, one serves dest
  logic [XLEN-1:0] bank_ab [NR];
  logic [XLEN-1:0] bank_d  [NR];
  logic [NR-1:0]   valid_q;

  logic [XLEN-1:0] r0_q, r0_d, r0_nx;
  logic [XLEN-1:0] cnt_q, cnt_d;
  logic [XLEN-1:0] plen_q;
  logic            halt_q, halt_d;

  logic            e_valid_q, e_valid_d;
  tre_pkg::instr_t e_instr_q;
  logic [XLEN-1:0] e_va_q, e_vb_q, e_vd_q;

  logic            fire, load, ok;
  logic [XLEN-1:0] alu;
  logic            wr_en;
  logic            byp_a, byp_b, byp_d;
  logic [XLEN-1:0] bval_a, bval_b, bval_d;

  assign fire        = e_valid_q && !res_full_i;
  assign load        = instr_valid_i && (!e_valid_q || !res_full_i);
  assign instr_pop_o = load;
  assign ok          = (cnt_q < plen_q) && !halt_q;

  always_comb begin
    case (e_instr_q.op)
      tre_pkg::OP_MOV:  alu = e_va_q;
      tre_pkg::OP_LOAD: alu = XLEN'(e_instr_q.imm);
      tre_pkg::OP_XOR:  alu = e_va_q ^ e_vb_q;
      tre_pkg::OP_ROTL: alu = tre_pkg::rotl32(e_va_q, e_instr_q.imm);
      tre_pkg::OP_ROTR: alu = tre_pkg::rotr32(e_va_q, e_instr_q.imm);
      tre_pkg::OP_ADD:  alu = e_va_q + e_vb_q;
      tre_pkg::OP_SUB:  alu = e_va_q - e_vb_q;
      tre_pkg::OP_LOW:  alu = e_va_q & tre_pkg::LOW_MASK;
      tre_pkg::OP_HIGH: alu = e_va_q >> tre_pkg::HALF_SHIFT;
      tre_pkg::OP_MIX:  alu = tre_pkg::mix32(e_va_q);
      default:          alu = '0;
    endcase
  end

  // register 0 lives in r0_q; banks hold the others
  always_comb begin
    r0_nx = r0_q;
    if (ok) begin
      if (e_instr_q.wr_dest && (e_instr_q.dest == '0)) begin
        r0_nx = e_instr_q.fold ? '0 : alu;
      end else if (e_instr_q.fold) begin
        r0_nx = r0_q ^ alu;
      end
    end
  end

  assign wr_en  = fire && ok && e_instr_q.wr_dest && (e_instr_q.dest != '0);
  assign r0_d   = fire ? r0_nx : r0_q;
  assign cnt_d  = (fire && ok) ? cnt_q + 1'b1 : cnt_q;
  assign halt_d = halt_q || (fire && ok && (e_instr_q.op == tre_pkg::OP_HALT));

  always_comb begin
    e_valid_d = e_valid_q;
    if (load) begin
      e_valid_d = 1'b1;
    end else if (fire) begin
      e_valid_d = 1'b0;
    end
  end

  // bypass of the write-back retiring at the same edge
  assign byp_a  = (instr_i.src_a == '0) || (wr_en && (e_instr_q.dest == instr_i.src_a));
  assign byp_b  = (instr_i.src_b == '0) || (wr_en && (e_instr_q.dest == instr_i.src_b));
  assign byp_d  = (instr_i.dest == '0) || (wr_en && (e_instr_q.dest == instr_i.dest));
  assign bval_a = (instr_i.src_a == '0) ? r0_d : alu;
  assign bval_b = (instr_i.src_b == '0) ? r0_d : alu;
  assign bval_d = (instr_i.dest == '0) ? r0_d : alu;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      r0_q      <= '0;
      cnt_q     <= '0;
      halt_q    <= 1'b0;
      plen_q    <= '1;
      e_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[e_instr_q.dest] <= 1'b1;
      end
      r0_q      <= r0_d;
      cnt_q     <= cnt_d;
      halt_q    <= halt_d;
      e_valid_q <= e_valid_d;
      if (cfg_we_i) begin
        plen_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bank_ab[e_instr_q.dest] <= alu;
      bank_d[e_instr_q.dest]  <= alu;
    end
    if (load) begin
      e_instr_q <= instr_i;
      e_va_q    <= byp_a ? bval_a : (valid_q[instr_i.src_a] ? bank_ab[instr_i.src_a] : '0);
      e_vb_q    <= byp_b ? bval_b : (valid_q[instr_i.src_b] ? bank_ab[instr_i.src_b] : '0);
      e_vd_q    <= byp_d ? bval_d : (valid_q[instr_i.dest] ? bank_d[instr_i.dest] : '0);
    end
  end

  always_comb begin
    res_o.executed   = ok;
    res_o.step_count = cnt_d;
    res_o.acc_value  = r0_nx;
    res_o.halted     = halt_d;
    if (e_instr_q.dest == '0) begin
      res_o.dest_value = r0_nx;
    end else if (ok && e_instr_q.wr_dest) begin
      res_o.dest_value = alu;
    end else begin
      res_o.dest_value = e_vd_q;
    end
  end

  assign res_push_o = fire;

  `TRE_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halt flag cleared")
  `TRE_ASSERT_NEXT(a_cnt_step, fire && ok, cnt_q == $past(cnt_q) + 1'b1,
                   "step count not advanced by one")
  `TRE_ASSERT_NEXT(a_ignored_quiet, fire && !ok, $stable(r0_q) && $stable(cnt_q),
                   "ignored request changed state")
  `TRE_ASSERT(a_no_fire_idle, !e_valid_q |-> !res_push_o, "result from empty stage")

endmodule
`default_nettype wire

@@ design/tiny_register_cpu_execute.sv @@
// Execute block of a tiny register machine: front decode, queues, back end
// Accepts one instruction request per cycle while full is low and returns one result per
// request in order. A request passes the instruction queue, the execute stage and the
// result queue; the sustained rate is one instruction per cycle while the result queue
// is not full, set by the single execute stage, whose register read is taken at the edge
// the request enters it with the write-back of the instruction ahead bypassed into it.
// An instruction queue of IQ_DEPTH entries sits between decode and execute, and a result
// queue of RQ_DEPTH entries holds results until popped; full mirrors the instruction queue.
`default_nettype none
module tiny_register_cpu_execute #(
  parameter int unsigned IQ_DEPTH = tre_pkg::IQ_DEPTH,
  parameter int unsigned RQ_DEPTH = tre_pkg::RQ_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [4:0]  opcode_i,
  input  wire logic [2:0]  dest_reg_i,
  input  wire logic [2:0]  src_a_i,
  input  wire logic [2:0]  src_b_i,
  input  wire logic [1:0]  small_imm_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             executed_o,
  output logic [31:0]      step_count_o,
  output logic [31:0]      dest_value_o,
  output logic [31:0]      acc_value_o,
  output logic             halted_o
);

  localparam int unsigned IW = $bits(tre_pkg::instr_t);
  localparam int unsigned RW = $bits(tre_pkg::res_t);

  tre_pkg::instr_t front_instr, iq_head;
  tre_pkg::res_t   back_res, rq_head;
  logic [IW-1:0]   iq_rdata;
  logic [RW-1:0]   rq_rdata;
  logic            iq_empty, iq_pop;
  logic            rq_push, rq_full;

  tre_front u_front (
    .opcode_i    (opcode_i),
    .dest_reg_i  (dest_reg_i),
    .src_a_i     (src_a_i),
    .src_b_i     (src_b_i),
    .small_imm_i (small_imm_i),
    .instr_o     (front_instr)
  );

  tre_fifo #(
    .WIDTH (IW),
    .DEPTH (IQ_DEPTH)
  ) u_iq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_instr),
    .full_o  (full),
    .pop_i   (iq_pop),
    .data_o  (iq_rdata),
    .empty_o (iq_empty)
  );

  assign iq_head = iq_rdata;

  tre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .instr_i       (iq_head),
    .instr_valid_i (!iq_empty),
    .instr_pop_o   (iq_pop),
    .res_o         (back_res),
    .res_push_o    (rq_push),
    .res_full_i    (rq_full)
  );

  tre_fifo #(
    .WIDTH (RW),
    .DEPTH (RQ_DEPTH)
  ) u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (back_res),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_rdata),
    .empty_o (empty)
  );

  assign rq_head      = rq_rdata;
  assign executed_o   = rq_head.executed;
  assign step_count_o = rq_head.step_count;
  assign dest_value_o = rq_head.dest_value;
  assign acc_value_o  = rq_head.acc_value;
  assign halted_o     = rq_head.halted;

endmodule
`default_nettype wire
